// ----- rtl/mmit_pkg.sv -----
package mmit_pkg;

  // Field and register widths
  localparam int NOW_W      = 32;
  localparam int INTERVAL_W = 32;
  localparam int REM_W      = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Default internal time width
  localparam int TIME_WIDTH_DEF = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd1;

  // Timer modes
  localparam logic [MODE_W-1:0] MODE_COUNTDOWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON_DELAY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLASH     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PING      = 2'd3;

  // Reset values of the configuration registers
  localparam logic [MODE_W-1:0]     MODE_RESET     = MODE_COUNTDOWN;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd1000;

endpackage

// ----- rtl/mmit_in_if.sv -----
interface mmit_in_if import mmit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NOW_W-1:0]  now_ms;
  logic              trigger;
  logic              suspend;
  logic              cancel;
  logic              restart;

  modport source (output valid, now_ms, trigger, suspend, cancel, restart, input ready);
  modport sink   (input valid, now_ms, trigger, suspend, cancel, restart, output ready);
endinterface

// ----- rtl/mmit_out_if.sv -----
interface mmit_out_if import mmit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              out;
  logic [REM_W-1:0]  remaining_ms;

  modport source (output valid, out, remaining_ms, input ready);
  modport sink   (input valid, out, remaining_ms, output ready);
endinterface

// ----- rtl/multi_mode_interval_timer.sv -----
// A result passes the input register, then the result register, before it can transfer out.
// Throughput: one item per cycle while out_ch.ready does not stall the result register;
// the timer update is adds, subtracts and compares, done combinationally
// between the input register and the result register.
// Reset (rst_n low, synchronous): pipeline empty, mode countdown, interval 1000 ms,
// timer state cleared.
module multi_mode_interval_timer import mmit_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mmit_in_if.sink               in_ch,
  mmit_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TW = TIME_WIDTH;
  // compare width: wide enough for both elapsed time and interval
  localparam int CW = (TW > INTERVAL_W) ? TW : INTERVAL_W;

  // Configuration registers
  logic [MODE_W-1:0]     mode_r;
  logic [INTERVAL_W-1:0] interval_r;

  // Timer state
  logic [TW-1:0] start_r, start_nxt;
  logic          active_r, active_nxt;
  logic          rearm_r, rearm_nxt;
  logic [TW-1:0] ptime_r, ptime_nxt;
  logic          pvalid_r, pvalid_nxt;

  // Input register
  logic          s1_valid_r;
  logic [TW-1:0] s1_now_r;
  logic          s1_trig_r, s1_susp_r, s1_canc_r, s1_rst_r;

  // Result register
  logic             o_valid_r;
  logic             o_out_r, o_out_nxt;
  logic [REM_W-1:0] o_rem_r, o_rem_nxt;

  logic adv;

  function automatic logic expired(input logic [TW-1:0] now, input logic [TW-1:0] start,
                                   input logic [INTERVAL_W-1:0] iv);
    logic [TW-1:0] e;
    e = now - start;
    return CW'(e) >= CW'(iv);
  endfunction

  function automatic logic [REM_W-1:0] remaining(input logic [TW-1:0] now,
                                                 input logic [TW-1:0] start,
                                                 input logic [INTERVAL_W-1:0] iv);
    logic [TW-1:0] e;
    logic [CW-1:0] d;
    e = now - start;
    d = CW'(iv) - CW'(e);
    return (CW'(iv) > CW'(e)) ? REM_W'(d) : '0;
  endfunction

  // Handshake: stage 1 moves on when the result register is free or draining
  assign adv          = s1_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign out_ch.valid = o_valid_r;
  assign out_ch.out   = o_out_r;
  assign out_ch.remaining_ms = o_rem_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:     mode_r     <= cfg_wdata[MODE_W-1:0];
        REG_INTERVAL: interval_r <= cfg_wdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Timer evaluation for the item in stage 1
  always_comb begin
    start_nxt  = start_r;
    active_nxt = active_r;
    rearm_nxt  = rearm_r;
    ptime_nxt  = ptime_r;
    pvalid_nxt = pvalid_r;
    o_out_nxt  = 1'b0;
    o_rem_nxt  = '0;
    if (s1_rst_r) begin
      start_nxt  = s1_now_r;
      active_nxt = 1'b0;
      rearm_nxt  = 1'b0;
      pvalid_nxt = 1'b0;
      o_rem_nxt  = interval_r;
    end else begin
      unique case (mode_r)
        MODE_COUNTDOWN: begin
          if (!active_r && !rearm_r && s1_trig_r) begin
            start_nxt  = s1_now_r;
            active_nxt = 1'b1;
          end
          if (rearm_r && !s1_trig_r) rearm_nxt = 1'b0;
          if (active_nxt) begin
            // suspend: slide start forward by the time spent paused
            if (s1_susp_r) begin
              if (pvalid_r) start_nxt = start_nxt + (s1_now_r - ptime_r);
              ptime_nxt  = s1_now_r;
              pvalid_nxt = 1'b1;
            end else begin
              pvalid_nxt = 1'b0;
            end
            if (expired(s1_now_r, start_nxt, interval_r) || s1_canc_r) begin
              start_nxt  = '0;
              active_nxt = 1'b0;
              pvalid_nxt = 1'b0;
              rearm_nxt  = s1_trig_r;
            end
          end
          o_out_nxt = active_nxt;
          o_rem_nxt = active_nxt ? remaining(s1_now_r, start_nxt, interval_r) : '0;
        end
        MODE_ON_DELAY: begin
          if (s1_trig_r) begin
            if (expired(s1_now_r, start_r, interval_r)) active_nxt = 1'b1;
          end else begin
            start_nxt  = s1_now_r;
            active_nxt = 1'b0;
          end
          o_out_nxt = active_nxt;
          o_rem_nxt = active_nxt ? '0 : remaining(s1_now_r, start_nxt, interval_r);
        end
        MODE_FLASH: begin
          if (expired(s1_now_r, start_r, interval_r)) begin
            active_nxt = !active_r;
            start_nxt  = s1_now_r;
          end
          o_out_nxt = active_nxt;
          o_rem_nxt = remaining(s1_now_r, start_nxt, interval_r);
        end
        MODE_PING: begin
          if (expired(s1_now_r, start_r, interval_r)) begin
            start_nxt = s1_now_r;
            o_out_nxt = 1'b1;
          end
          o_rem_nxt = remaining(s1_now_r, start_nxt, interval_r);
        end
        default: ;
      endcase
    end
  end

  // Pipeline control and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
      start_r    <= '0;
      active_r   <= 1'b0;
      rearm_r    <= 1'b0;
      ptime_r    <= '0;
      pvalid_r   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) s1_valid_r <= 1'b1;
      else if (adv)                   s1_valid_r <= 1'b0;
      if (adv)               o_valid_r <= 1'b1;
      else if (out_ch.ready) o_valid_r <= 1'b0;
      if (adv) begin
        start_r  <= start_nxt;
        active_r <= active_nxt;
        rearm_r  <= rearm_nxt;
        ptime_r  <= ptime_nxt;
        pvalid_r <= pvalid_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_now_r  <= TW'(in_ch.now_ms);
      s1_trig_r <= in_ch.trigger;
      s1_susp_r <= in_ch.suspend;
      s1_canc_r <= in_ch.cancel;
      s1_rst_r  <= in_ch.restart;
    end
    if (adv) begin
      o_out_r <= o_out_nxt;
      o_rem_r <= o_rem_nxt;
    end
  end

endmodule
